### rtl/fixed_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for fixed_to_decimal_ascii
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_TO_DECIMAL_ASCII_MACROS_SVH
`define FIXED_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define F2DA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("f2da: same-cycle check failed");

// next-cycle implication
`define F2DA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("f2da: next-cycle check failed");

`endif

### rtl/f2da_pkg.sv
// ----------------------------------------------------------------------------
// f2da_pkg
// Constants, control word types and microcode ROM for the fixed-point to
// decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package f2da_pkg;

  // number format
  localparam int INT_BITS            = 32;
  localparam int FRAC_BITS           = 32;
  localparam int IN_W                = INT_BITS + FRAC_BITS;
  localparam int MAX_FRACTION_DIGITS = 16;
  localparam int FD_W                = 5;
  localparam int INT_DIGITS          = 10;  // decimal digits of a 32-bit integer
  localparam int SP_W                = $clog2(INT_DIGITS + 1);
  localparam int IDX_W               = $clog2(INT_DIGITS);

  // divide by ten: q = (x * RECIP10) >> RECIP_SH, exact for x < 2**32
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  localparam logic [FD_W-1:0] FD_RESET = FD_W'(10);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_POINT = 8'd46;

  // microprogram
  localparam int PC_W = 3;

  localparam logic [PC_W-1:0] STEP_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_MUL   = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_DIV   = PC_W'(2);
  localparam logic [PC_W-1:0] STEP_INT   = PC_W'(3);
  localparam logic [PC_W-1:0] STEP_POINT = PC_W'(4);
  localparam logic [PC_W-1:0] STEP_FRAC  = PC_W'(5);
  localparam logic [PC_W-1:0] STEP_DONE  = PC_W'(6);

  typedef enum logic [1:0] {
    EM_NONE  = 2'd0,
    EM_INT   = 2'd1,
    EM_POINT = 2'd2,
    EM_FRAC  = 2'd3
  } emit_e;

  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_Q_NZ     = 3'd2,
    CND_SP_MORE  = 3'd3,
    CND_CNT_MORE = 3'd4
  } cond_e;

  typedef struct packed {
    logic            wait_in;  // hold until an input word arrives, then load
    logic            mul;      // reciprocal multiply of the integer part
    logic            div;      // take quotient, push remainder digit
    emit_e           emit;     // character to send, holds while output busy
    cond_e           cond;     // jump to target when true, else next step
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic q_nz;
    logic sp_more;
    logic cnt_more;
  } stat_t;

  function automatic ctrl_t rom_word(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{wait_in: 1'b0, mul: 1'b0, div: 1'b0, emit: EM_NONE,
          cond: CND_ALWAYS, target: STEP_IDLE};
    case (pc)
      STEP_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = CND_NEVER;
      end
      STEP_MUL: begin
        w.mul  = 1'b1;
        w.cond = CND_NEVER;
      end
      STEP_DIV: begin
        w.div    = 1'b1;
        w.cond   = CND_Q_NZ;
        w.target = STEP_MUL;
      end
      STEP_INT: begin
        w.emit   = EM_INT;
        w.cond   = CND_SP_MORE;
        w.target = STEP_INT;
      end
      STEP_POINT: begin
        w.emit = EM_POINT;
        w.cond = CND_NEVER;
      end
      STEP_FRAC: begin
        w.emit   = EM_FRAC;
        w.cond   = CND_CNT_MORE;
        w.target = STEP_FRAC;
      end
      STEP_DONE: begin
        w.cond   = CND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = CND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/f2da_seq.sv
// ----------------------------------------------------------------------------
// f2da_seq
// Step counter and microcode ROM: holds a step on stall, else jumps or steps.
// ----------------------------------------------------------------------------
`default_nettype none

module f2da_seq (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire f2da_pkg::stat_t stat_i,
  output f2da_pkg::ctrl_t  ctrl_o,
  output logic             go_o
);
  import f2da_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           cw;
  logic            stall;
  logic            take;

  assign cw = rom_word(pc_q);

  // stall on a missing input word or a busy output register
  assign stall = (cw.wait_in && !stat_i.in_valid) ||
                 ((cw.emit != EM_NONE) && !stat_i.out_free);

  always_comb begin
    case (cw.cond)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_Q_NZ:     take = stat_i.q_nz;
      CND_SP_MORE:  take = stat_i.sp_more;
      CND_CNT_MORE: take = stat_i.cnt_more;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (!stall) begin
      pc_d = take ? cw.target : pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = cw;
  assign go_o   = !stall;

endmodule

`default_nettype wire

### rtl/f2da_dp.sv
// ----------------------------------------------------------------------------
// f2da_dp
// Datapath: integer and fraction registers, divide-by-ten multiplier, digit
// stack, fraction-times-ten step, output register and config register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_to_decimal_ascii_macros.svh"

module f2da_dp (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire f2da_pkg::ctrl_t             ctrl_i,
  input  wire                              go_i,
  output f2da_pkg::stat_t                  stat_o,
  input  wire                              in_valid_i,
  input  wire  [f2da_pkg::IN_W-1:0]        in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic [7:0]                       out_char_o,
  output logic                             out_last_o,
  input  wire                              cfg_valid_i,
  input  wire  [f2da_pkg::FD_W-1:0]        cfg_data_i
);
  import f2da_pkg::*;

  logic [FD_W-1:0]      fd_q;
  logic [INT_BITS-1:0]  int_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [63:0]          prod_q;
  logic [3:0]           stack_q [INT_DIGITS];
  logic [SP_W-1:0]      sp_q;
  logic [FD_W-1:0]      cnt_q;
  logic                 oval_q;
  logic [7:0]           ochar_q;
  logic                 olast_q;

  logic                 out_free;
  logic                 load;
  logic                 emit_go;
  logic [FD_W-1:0]      nfrac;
  logic [INT_BITS-1:0]  quot;
  logic [INT_BITS-1:0]  rem_full;
  logic [3:0]           rem;
  logic [FRAC_BITS+3:0] frac10;
  logic [IDX_W-1:0]     pop_idx;
  logic [7:0]           char_d;

  assign out_free = !oval_q || out_ready_i;
  assign load     = go_i && ctrl_i.wait_in;
  assign emit_go  = go_i && (ctrl_i.emit != EM_NONE);

  // fraction digit count, clamped to 1..MAX_FRACTION_DIGITS
  always_comb begin
    if (fd_q == '0) begin
      nfrac = FD_W'(1);
    end else if (fd_q > FD_W'(MAX_FRACTION_DIGITS)) begin
      nfrac = FD_W'(MAX_FRACTION_DIGITS);
    end else begin
      nfrac = fd_q;
    end
  end

  // quotient and remainder from the registered product
  assign quot     = INT_BITS'(prod_q >> RECIP_SH);
  assign rem_full = int_q - ((quot << 3) + (quot << 1));
  assign rem      = rem_full[3:0];

  // fraction times ten: top four bits are the digit
  assign frac10 = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1);

  assign pop_idx = IDX_W'(sp_q - SP_W'(1));

  always_comb begin
    case (ctrl_i.emit)
      EM_INT:   char_d = CHAR_ZERO + {4'b0, stack_q[pop_idx]};
      EM_POINT: char_d = CHAR_POINT;
      EM_FRAC:  char_d = CHAR_ZERO + {4'b0, frac10[FRAC_BITS+3:FRAC_BITS]};
      default:  char_d = CHAR_POINT;
    endcase
  end

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q <= FD_RESET;
    end else if (cfg_valid_i) begin
      fd_q <= cfg_data_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (load) begin
        sp_q  <= '0;
        cnt_q <= nfrac;
      end else if (go_i && ctrl_i.div) begin
        sp_q <= sp_q + SP_W'(1);
      end else if (go_i && ctrl_i.emit == EM_INT) begin
        sp_q <= sp_q - SP_W'(1);
      end else if (go_i && ctrl_i.emit == EM_FRAC) begin
        cnt_q <= cnt_q - FD_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      int_q  <= in_data_i[IN_W-1:FRAC_BITS];
      frac_q <= in_data_i[FRAC_BITS-1:0];
    end else if (go_i && ctrl_i.div) begin
      int_q <= quot;
    end else if (go_i && ctrl_i.emit == EM_FRAC) begin
      frac_q <= frac10[FRAC_BITS-1:0];
    end
    if (go_i && ctrl_i.mul) begin
      prod_q <= int_q * RECIP10;
    end
    if (go_i && ctrl_i.div) begin
      stack_q[IDX_W'(sp_q)] <= rem;
    end
    if (emit_go) begin
      ochar_q <= char_d;
      olast_q <= (ctrl_i.emit == EM_FRAC) && (cnt_q == FD_W'(1));
    end
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (emit_go) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  assign stat_o = '{in_valid: in_valid_i, out_free: out_free, q_nz: (quot != '0),
                    sp_more: (sp_q != SP_W'(1)), cnt_more: (cnt_q != FD_W'(1))};

  assign out_valid_o = oval_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

  `F2DA_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= SP_W'(INT_DIGITS))
  `F2DA_ASSERT_NOW(a_pop_nonempty, emit_go && ctrl_i.emit == EM_INT, sp_q != '0)
  `F2DA_ASSERT_NOW(a_cnt_live, emit_go && ctrl_i.emit == EM_FRAC, cnt_q != '0)
  `F2DA_ASSERT_NXT(a_last_frac, emit_go && ctrl_i.emit == EM_FRAC && cnt_q == FD_W'(1),
                   oval_q && olast_q)

endmodule

`default_nettype wire

### rtl/fixed_to_decimal_ascii.sv
// Steps per value: load, a multiply and a divide per integer digit, a pop
//   per integer digit, the point, one per fraction digit, then done.
// Throughput: one value at a time; each integer digit costs a multiply and a
//   divide step on the shared reciprocal multiplier, then one pop to output.
// Reset: async active low; fraction_digits returns to 10, sequencer idles.
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii
// Unsigned Q32.32 to decimal ASCII text, one character per output word.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_to_decimal_ascii (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [f2da_pkg::IN_W-1:0]    s_axis_tdata,   // [63:0] value_fixed
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [7:0]                   m_axis_tdata,   // [7:0] ascii_char
  output logic                         m_axis_tlast,   // last_char
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [f2da_pkg::FD_W-1:0]    cfg_data_i      // fraction_digits
);
  import f2da_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  go;

  f2da_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .go_o   (go)
  );

  f2da_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .go_i        (go),
    .stat_o      (stat),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i)
  );

  // ready only on the load step
  assign s_axis_tready = ctrl.wait_in;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire
